[rtl/sks_pkg.sv]
package sks_pkg;

  localparam int SAMPLE_BITS            = 12;
  localparam int ESTIMATE_FRACTION_BITS = 8;
  localparam int EST_BITS               = SAMPLE_BITS + ESTIMATE_FRACTION_BITS;
  localparam int ERR_BITS               = 32;
  localparam int GAIN_BITS              = 16;
  localparam int CFG_INDEX_BITS         = 2;
  localparam int CFG_DATA_BITS          = 32;

  // gain divider produces one quotient bit per step, including the integer bit
  localparam int DIV_STEPS      = GAIN_BITS + 1;
  localparam int STEP_CNT_BITS  = $clog2(DIV_STEPS);

  localparam logic [ERR_BITS-1:0]  NOISE_RESET   = 32'd131072;
  localparam logic [ERR_BITS-1:0]  ERROR_RESET   = 32'd131072;
  localparam logic [ERR_BITS-1:0]  PGAIN_RESET   = 32'd655;
  localparam logic [ERR_BITS-1:0]  ERR_MAX       = '1;
  localparam logic [GAIN_BITS-1:0] GAIN_MAX      = '1;
  localparam logic [GAIN_BITS:0]   GAIN_ONE      = {1'b1, {GAIN_BITS{1'b0}}};

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MEASURE_NOISE = 2'd0,
    REG_INITIAL_ERROR = 2'd1,
    REG_PROCESS_GAIN  = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DELTA,
    ST_KEEP,
    ST_ADD,
    ST_SUM,
    ST_OUT
  } seq_state_t;

endpackage

[rtl/sks_if.sv]
interface sks_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [sks_pkg::CFG_INDEX_BITS-1:0]  index;
  logic [sks_pkg::CFG_DATA_BITS-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

interface sks_sample_if;
  logic                             valid;
  logic                             ready;
  logic [sks_pkg::SAMPLE_BITS-1:0]  sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface sks_estimate_if;
  logic                          valid;
  logic                          ready;
  logic [sks_pkg::EST_BITS-1:0]  estimate;
  modport source (output valid, output estimate, input ready);
  modport sink   (input valid, input estimate, output ready);
endinterface

[rtl/scalar_kalman_smoother_unit.sv]
// One-dimensional Kalman smoother in fixed point. Each sample transaction (unsigned
// integer) produces exactly one estimate transaction in unsigned Q12.8. Per sample the
// block forms gain = P/(P+R) in Q0.16, moves the estimate toward the sample by
// round(gain*|sample-estimate|), and updates the error P = round((1-gain)*P) +
// round(delta*q) with saturation at all ones. R, P and q are unsigned Q16.16. A sample
// passes from acceptance through the restoring gain divider (one quotient bit per cycle),
// a hand-over of the gain to the sequencer, then three passes through one shared 32x20
// registered multiplier, a rounding/saturating add and the output load.
// The sample side is not ready while a sample is in work; a finished estimate sits in
// an output register, so the next sample is taken even while that estimate waits.
// The configuration port is always ready: index 0 writes R, index 1 reloads P and
// clears the estimate, index 2 writes q, other indexes are ignored. Write it only
// while no sample is in work.
module scalar_kalman_smoother_unit (
  input  logic           clk,
  input  logic           rst,
  sks_cfg_if.sink        cfg,
  sks_sample_if.sink     samples,
  sks_estimate_if.source estimates
);
  import sks_pkg::*;

  // multiplier b operand must hold an estimate difference and (1 - gain)
  localparam int MUL_B_BITS = (EST_BITS > GAIN_BITS + 1) ? EST_BITS : GAIN_BITS + 1;
  localparam int PROD_BITS  = ERR_BITS + MUL_B_BITS;
  localparam int ADD_BITS   = PROD_BITS - ESTIMATE_FRACTION_BITS + 1;
  localparam int SUM_BITS   = ADD_BITS + 1;
  localparam logic [PROD_BITS:0] ROUND_GAIN = (PROD_BITS+1)'(1) << (GAIN_BITS - 1);
  localparam logic [PROD_BITS:0] ROUND_FRAC =
    (PROD_BITS+1)'(1) << (ESTIMATE_FRACTION_BITS - 1);

  // filter state and configuration
  logic [ERR_BITS-1:0]  measure_noise;
  logic [ERR_BITS-1:0]  process_gain;
  logic [ERR_BITS-1:0]  error_estimate;
  logic [EST_BITS-1:0]  prior_estimate;

  // per-sample working registers
  logic [EST_BITS-1:0]  mag;
  logic                 toward_up;
  logic [EST_BITS-1:0]  delta;
  logic [ERR_BITS:0]    keep;
  logic [PROD_BITS-1:0] prod;

  // output register
  logic                 out_valid;
  logic [EST_BITS-1:0]  out_estimate;

  seq_state_t state, state_next;

  logic                 accept;
  logic                 out_load;
  logic                 cfg_write;
  logic                 div_done;
  logic [GAIN_BITS-1:0] gain;

  logic [EST_BITS-1:0]  sample_q;
  logic [ERR_BITS-1:0]  mul_a;
  logic [MUL_B_BITS-1:0] mul_b;
  logic [GAIN_BITS:0]   one_minus_gain;
  logic [PROD_BITS:0]   prod_rnd_gain;
  logic [PROD_BITS:0]   prod_rnd_frac;
  logic [SUM_BITS-1:0]  err_sum;
  logic [EST_BITS-1:0]  est_next;

  assign cfg.ready          = 1'b1;
  assign cfg_write          = cfg.valid;
  assign samples.ready      = (state == ST_IDLE);
  assign accept             = samples.valid && samples.ready;
  assign estimates.valid    = out_valid;
  assign estimates.estimate = out_estimate;

  // sample moved into estimate format (integer part, zero fraction)
  assign sample_q = {samples.sample, {ESTIMATE_FRACTION_BITS{1'b0}}};

  sks_gain_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .p     (error_estimate),
    .r     (measure_noise),
    .done  (div_done),
    .gain  (gain)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_DIV;
      ST_DIV:   if (div_done) state_next = ST_DELTA;
      ST_DELTA: state_next = ST_KEEP;
      ST_KEEP:  state_next = ST_ADD;
      ST_ADD:   state_next = ST_SUM;
      ST_SUM:   state_next = ST_OUT;
      ST_OUT: begin
        // wait until the output register is free
        if (!out_valid || estimates.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // shared multiplier operand select: gain*mag, (1-gain)*P, q*delta
  assign one_minus_gain = GAIN_ONE - {1'b0, gain};

  always_comb begin
    unique case (state)
      ST_DELTA: begin
        mul_a = ERR_BITS'(gain);
        mul_b = MUL_B_BITS'(mag);
      end
      ST_KEEP: begin
        mul_a = error_estimate;
        mul_b = MUL_B_BITS'(one_minus_gain);
      end
      ST_ADD: begin
        mul_a = process_gain;
        mul_b = MUL_B_BITS'(delta);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // rounding of the registered product, and the final error sum
  assign prod_rnd_gain = {1'b0, prod} + ROUND_GAIN;
  assign prod_rnd_frac = {1'b0, prod} + ROUND_FRAC;
  assign err_sum       = SUM_BITS'(keep)
                       + SUM_BITS'(prod_rnd_frac[PROD_BITS:ESTIMATE_FRACTION_BITS]);
  assign est_next      = toward_up ? (prior_estimate + delta) : (prior_estimate - delta);

  always_ff @(posedge clk) begin
    if (accept) begin
      toward_up <= (sample_q >= prior_estimate);
      mag       <= (sample_q >= prior_estimate) ? (sample_q - prior_estimate)
                                                : (prior_estimate - sample_q);
    end
    if (state == ST_KEEP) begin
      delta <= prod_rnd_gain[GAIN_BITS +: EST_BITS];
    end
    if (state == ST_ADD) begin
      keep <= prod_rnd_gain[GAIN_BITS +: ERR_BITS + 1];
    end
  end

  // configuration registers and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      measure_noise  <= NOISE_RESET;
      process_gain   <= PGAIN_RESET;
      error_estimate <= ERROR_RESET;
      prior_estimate <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg.index)
          REG_MEASURE_NOISE: measure_noise <= cfg.data;
          REG_INITIAL_ERROR: begin
            error_estimate <= cfg.data;
            prior_estimate <= '0;
          end
          REG_PROCESS_GAIN:  process_gain <= cfg.data;
          default: ;
        endcase
      end
      if (state == ST_SUM) begin
        prior_estimate <= est_next;
        // saturate P at all ones
        if (|err_sum[SUM_BITS-1:ERR_BITS]) begin
          error_estimate <= ERR_MAX;
        end else begin
          error_estimate <= err_sum[ERR_BITS-1:0];
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (estimates.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_estimate <= prior_estimate;
    end
  end

endmodule

[rtl/sks_gain_div.sv]
module sks_gain_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [sks_pkg::ERR_BITS-1:0]   p,
  input  logic [sks_pkg::ERR_BITS-1:0]   r,
  output logic                           done,
  output logic [sks_pkg::GAIN_BITS-1:0]  gain
);
  import sks_pkg::*;

  localparam logic [STEP_CNT_BITS-1:0] LAST_STEP = STEP_CNT_BITS'(DIV_STEPS - 1);

  logic [ERR_BITS:0]        den;
  logic [ERR_BITS+1:0]      rem;
  logic [GAIN_BITS:0]       quo;
  logic [STEP_CNT_BITS-1:0] cnt;
  logic                     running;
  logic                     den_zero;

  logic [ERR_BITS+1:0]      trial;
  logic [ERR_BITS+1:0]      diff;
  logic                     fits;
  logic [GAIN_BITS:0]       quo_next;

  // first step compares p itself (integer bit), later steps shift in a zero
  always_comb begin
    trial    = (cnt == '0) ? rem : {rem[ERR_BITS:0], 1'b0};
    fits     = trial >= {1'b0, den};
    diff     = trial - {1'b0, den};
    quo_next = {quo[GAIN_BITS-1:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        den      <= {1'b0, p} + {1'b0, r};
        rem      <= {2'b00, p};
        quo      <= '0;
        cnt      <= '0;
        den_zero <= (p == '0) && (r == '0);
        running  <= 1'b1;
      end else if (running) begin
        rem <= fits ? diff : trial;
        quo <= quo_next;
        if (cnt == LAST_STEP) begin
          running <= 1'b0;
          done    <= 1'b1;
          if (den_zero) begin
            gain <= '0;
          end else if (quo_next[GAIN_BITS]) begin
            gain <= GAIN_MAX;
          end else begin
            gain <= quo_next[GAIN_BITS-1:0];
          end
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

[rtl/sks_checker.sv]
module sks_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_valid,
  input logic                          s_ready,
  input logic                          e_valid,
  input logic                          e_ready,
  input logic [sks_pkg::EST_BITS-1:0]  e_estimate
);
  import sks_pkg::*;

  // a stalled estimate holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    e_valid && !e_ready |=> e_valid && $stable(e_estimate))
    else $error("estimate changed or dropped while stalled");

  // an accepted sample makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_valid && s_ready |=> !s_ready)
    else $error("sample side ready right after a sample transaction");

  // a new estimate only comes out of a busy cycle
  a_estimate_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(e_valid) |-> $past(!s_ready))
    else $error("estimate appeared without a sample in work");

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !e_valid)
    else $error("estimate valid after reset");

endmodule

bind scalar_kalman_smoother_unit sks_checker u_sks_checker (
  .clk        (clk),
  .rst        (rst),
  .s_valid    (samples.valid),
  .s_ready    (samples.ready),
  .e_valid    (estimates.valid),
  .e_ready    (estimates.ready),
  .e_estimate (estimates.estimate)
);
